// ===== rtl/mtm_pkg.sv =====
// ----------------------------------------------------------------------------
// mtm_pkg
// Shared types, constants and tables for the MUS to MIDI event converter.
// ----------------------------------------------------------------------------
package mtm_pkg;

  localparam int FIFO_DEPTH_DEF = 2;

  localparam int DELTA_W = 28;
  localparam logic [DELTA_W-1:0] DELTA_MAX = 28'hFFF_FFFF;
  localparam logic [7:0] END_BYTE = 8'h60;

  // result status codes
  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // mus event types
  localparam logic [2:0] TY_NOTE_OFF = 3'd0;
  localparam logic [2:0] TY_NOTE_ON  = 3'd1;
  localparam logic [2:0] TY_PITCH    = 3'd2;
  localparam logic [2:0] TY_SYSTEM   = 3'd3;
  localparam logic [2:0] TY_CTRL     = 3'd4;
  localparam logic [2:0] TY_FIRST_BAD = 3'd5;

  // midi status nibbles
  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
  localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
  localparam logic [3:0] MIDI_CTRL     = 4'hB;
  localparam logic [3:0] MIDI_PROG     = 4'hC;
  localparam logic [3:0] MIDI_PITCH    = 4'hE;

  // serializer slots: four delta groups, three event bytes, four end bytes, status
  localparam int NSLOT = 12;
  localparam int SLOT_W = 4;

  typedef struct packed {
    logic               has_evt;
    logic               len3;
    logic               has_end;
    logic               fail;
    logic [7:0]         b0;
    logic [7:0]         b1;
    logic [7:0]         b2;
    logic [DELTA_W-1:0] delta;
  } cmd_t;

  function automatic logic [7:0] ctl_map(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'd0;
      4'd1:    r = 8'd0;
      4'd2:    r = 8'd1;
      4'd3:    r = 8'd7;
      4'd4:    r = 8'd10;
      4'd5:    r = 8'd11;
      4'd6:    r = 8'd91;
      4'd7:    r = 8'd93;
      4'd8:    r = 8'd64;
      4'd9:    r = 8'd67;
      4'd10:   r = 8'd120;
      4'd11:   r = 8'd123;
      4'd12:   r = 8'd126;
      4'd13:   r = 8'd127;
      4'd14:   r = 8'd121;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/mus_to_midi_event_converter.sv =====
// ----------------------------------------------------------------------------
// mus_to_midi_event_converter
// Converts a MUS score byte stream into MIDI track body bytes.
//
//   channel  ports                                 handshake
//   input    in_score_byte                         push / full
//   result   out_byte, out_last, out_status        empty / pop
//   config   cfg_wr_data (score length)            cfg_wr_en
//
// one score byte is taken per cycle while the command queue has room
// result bytes leave the serializer at one per cycle while the output is
// free or popped; a command holds the queue head until its last byte is
// loaded, and its first byte reaches the result ports through the queue and then the output register
// reset clears parse state, volume table, queue and the output valid flag
// a stalled pop backs up the queue, then full rises
// ----------------------------------------------------------------------------
module mus_to_midi_event_converter #(
  parameter int FIFO_DEPTH = mtm_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_score_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic [1:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0]   score_length_r;
  logic          in_ok;
  logic          cmd_valid, q_full, q_empty, q_pop, out_valid;
  mtm_pkg::cmd_t cmd, q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_length_r <= '0;
    end else if (cfg_wr_en) begin
      score_length_r <= cfg_wr_data;
    end
  end

  assign full  = q_full;
  assign in_ok = push && !q_full;
  assign empty = !out_valid;

  mtm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .score_length (score_length_r),
    .in_valid     (in_ok),
    .in_byte      (in_score_byte),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd)
  );

  mtm_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_cmd),
    .empty   (q_empty)
  );

  mtm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (!q_empty),
    .cmd        (q_cmd),
    .cmd_pop    (q_pop),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_status (out_status),
    .pop        (pop)
  );

  // end and error results close their transaction group
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != mtm_pkg::ST_DATA) |-> out_last)
    else $error("status result not marked last");

  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != mtm_pkg::ST_DATA) |-> (out_byte == 8'h00))
    else $error("status result carries data");

  assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && !q_cmd.fail) |-> (q_cmd.has_evt || q_cmd.has_end))
    else $error("queued command produces no bytes");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |-> $onehot0({cmd.fail, cmd.has_evt | cmd.has_end}))
    else $error("error command mixed with event or end");

endmodule

// ===== rtl/mtm_fifo.sv =====
// ----------------------------------------------------------------------------
// mtm_fifo
// Short command queue between the parser and the byte serializer.
// ----------------------------------------------------------------------------
module mtm_fifo #(
  parameter int DEPTH = mtm_pkg::FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  mtm_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output mtm_pkg::cmd_t rd_data,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mtm_pkg::cmd_t    mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (do_rd) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/mtm_front.sv =====
// ----------------------------------------------------------------------------
// mtm_front
// Score byte parser: tracks event phase, volumes, delays and byte count, and
// issues one command per byte that causes output.
// ----------------------------------------------------------------------------
module mtm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [15:0]   score_length,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  output logic          cmd_valid,
  output mtm_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_OP1,
    PH_OP2,
    PH_DELAY,
    PH_ENDED,
    PH_HALTED
  } phase_t;

  localparam int DW = mtm_pkg::DELTA_W;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      hdr_r, hdr_nxt;
  logic [7:0]      first_r, first_nxt;
  logic [7:0]      vol_r [16];
  logic [DW-1:0]   build_r, build_nxt;
  logic [DW-1:0]   pend_r, pend_nxt;
  logic [15:0]     cnt_r, cnt_nxt;

  logic [2:0]      ty;
  logic [3:0]      ch;
  logic [15:0]     cnt_inc;
  logic            vol_we;
  logic            ev, complete, finish;
  logic [DW-1:0]   build_step;
  logic [DW:0]     sum;
  mtm_pkg::cmd_t   c;

  function automatic logic [3:0] midi_ch(input logic [3:0] mc);
    logic [3:0] r;
    if (mc == 4'd15) begin
      r = 4'd9;
    end else if (mc >= 4'd9) begin
      r = mc + 4'd1;
    end else begin
      r = mc;
    end
    return r;
  endfunction

  assign ty      = hdr_r[6:4];
  assign ch      = midi_ch(hdr_r[3:0]);
  assign cnt_inc = (cnt_r == 16'hFFFF) ? cnt_r : cnt_r + 16'd1;

  assign build_step = (build_r > (mtm_pkg::DELTA_MAX >> 7)) ? mtm_pkg::DELTA_MAX
                    : {build_r[DW-8:0], in_byte[6:0]};
  assign sum = {1'b0, pend_r} + {1'b0, build_step};

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    first_nxt = first_r;
    build_nxt = build_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    vol_we    = 1'b0;
    ev        = 1'b0;
    complete  = 1'b0;
    finish    = 1'b0;
    c         = '0;
    c.delta   = pend_r;
    if (in_valid && phase_r != PH_ENDED && phase_r != PH_HALTED) begin
      if (phase_r == PH_HEADER && (cnt_r >= score_length || in_byte == mtm_pkg::END_BYTE)) begin
        c.has_end = 1'b1;
        phase_nxt = PH_ENDED;
      end else begin
        cnt_nxt = cnt_inc;
        case (phase_r)
          PH_HEADER: begin
            hdr_nxt = in_byte;
            if (in_byte[6:4] >= mtm_pkg::TY_FIRST_BAD) begin
              c.fail    = 1'b1;
              phase_nxt = PH_HALTED;
            end else begin
              phase_nxt = PH_OP1;
            end
          end
          PH_OP1: begin
            first_nxt = in_byte;
            case (ty)
              mtm_pkg::TY_NOTE_OFF: begin
                ev       = 1'b1;
                c.b0     = {mtm_pkg::MIDI_NOTE_OFF, ch};
                c.b1     = in_byte;
                c.len3   = 1'b1;
                complete = 1'b1;
              end
              mtm_pkg::TY_NOTE_ON: begin
                if (in_byte[7]) begin
                  phase_nxt = PH_OP2;
                end else begin
                  ev       = 1'b1;
                  c.b0     = {mtm_pkg::MIDI_NOTE_ON, ch};
                  c.b1     = in_byte;
                  c.b2     = vol_r[ch];
                  c.len3   = 1'b1;
                  complete = 1'b1;
                end
              end
              mtm_pkg::TY_PITCH: begin
                ev       = 1'b1;
                c.b0     = {mtm_pkg::MIDI_PITCH, ch};
                c.b2     = {1'b0, in_byte[7:1]};
                c.len3   = 1'b1;
                complete = 1'b1;
              end
              mtm_pkg::TY_SYSTEM: begin
                if (in_byte >= 8'd10 && in_byte <= 8'd14) begin
                  ev       = 1'b1;
                  c.b0     = {mtm_pkg::MIDI_CTRL, ch};
                  c.b1     = mtm_pkg::ctl_map(in_byte[3:0]);
                  c.b2     = 8'd1;
                  c.len3   = 1'b1;
                  complete = 1'b1;
                end else begin
                  c.fail    = 1'b1;
                  phase_nxt = PH_HALTED;
                end
              end
              default: begin
                if (in_byte < 8'd10) begin
                  phase_nxt = PH_OP2;
                end else begin
                  c.fail    = 1'b1;
                  phase_nxt = PH_HALTED;
                end
              end
            endcase
          end
          PH_OP2: begin
            ev       = 1'b1;
            complete = 1'b1;
            if (ty == mtm_pkg::TY_NOTE_ON) begin
              vol_we = 1'b1;
              c.b0   = {mtm_pkg::MIDI_NOTE_ON, ch};
              c.b1   = {1'b0, first_r[6:0]};
              c.b2   = in_byte;
              c.len3 = 1'b1;
            end else if (first_r == 8'd0) begin
              c.b0 = {mtm_pkg::MIDI_PROG, ch};
              c.b1 = in_byte;
            end else begin
              c.b0   = {mtm_pkg::MIDI_CTRL, ch};
              c.b1   = mtm_pkg::ctl_map(first_r[3:0]);
              c.b2   = in_byte;
              c.len3 = 1'b1;
            end
          end
          default: begin
            build_nxt = build_step;
            if (!in_byte[7]) begin
              pend_nxt = sum[DW] ? mtm_pkg::DELTA_MAX : sum[DW-1:0];
              finish   = 1'b1;
            end
          end
        endcase
      end
    end
    if (ev) begin
      c.has_evt = 1'b1;
      pend_nxt  = '0;
    end
    if (complete) begin
      if (hdr_r[7]) begin
        phase_nxt = PH_DELAY;
        build_nxt = '0;
      end else begin
        finish = 1'b1;
      end
    end
    if (finish) begin
      phase_nxt = PH_HEADER;
      if (cnt_inc >= score_length) begin
        c.has_end = 1'b1;
        phase_nxt = PH_ENDED;
      end
    end
  end

  assign cmd       = c;
  assign cmd_valid = c.has_evt || c.has_end || c.fail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hdr_r   <= '0;
      first_r <= '0;
      build_r <= '0;
      pend_r  <= '0;
      cnt_r   <= '0;
      for (int i = 0; i < 16; i++) begin
        vol_r[i] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      first_r <= first_nxt;
      build_r <= build_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
      if (vol_we) begin
        vol_r[ch] <= in_byte;
      end
    end
  end

endmodule

// ===== rtl/mtm_back.sv =====
// ----------------------------------------------------------------------------
// mtm_back
// Byte serializer: walks the slots of the command at the queue head and
// emits one midi byte per cycle into the output register while it is free or popped.
// ----------------------------------------------------------------------------
module mtm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  mtm_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic [1:0]    out_status,
  input  logic          pop
);

  localparam int NS = mtm_pkg::NSLOT;
  localparam int SW = mtm_pkg::SLOT_W;

  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic [1:0]    out_status_r;
  logic          started_r;
  logic [SW-1:0] pos_r;

  logic [NS-1:0] mask, rest;
  logic [SW-1:0] first_pos, eff_pos, nxt_pos;
  logic          nxt_found, unused_first_found;
  logic          advance, last;
  logic [7:0]    sel_byte;
  logic [1:0]    sel_status;

  function automatic logic [SW:0] lowest(input logic [NS-1:0] m);
    logic [SW:0] r;
    r = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = {1'b1, SW'(i)};
      end
    end
    return r;
  endfunction

  always_comb begin
    mask[0]  = cmd.has_evt && (cmd.delta[27:21] != '0);
    mask[1]  = cmd.has_evt && (cmd.delta[27:14] != '0);
    mask[2]  = cmd.has_evt && (cmd.delta[27:7] != '0);
    mask[3]  = cmd.has_evt;
    mask[4]  = cmd.has_evt;
    mask[5]  = cmd.has_evt;
    mask[6]  = cmd.has_evt && cmd.len3;
    mask[7]  = cmd.has_end;
    mask[8]  = cmd.has_end;
    mask[9]  = cmd.has_end;
    mask[10] = cmd.has_end;
    mask[11] = cmd.has_end || cmd.fail;
  end

  assign {unused_first_found, first_pos} = lowest(mask);
  assign eff_pos = started_r ? pos_r : first_pos;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      rest[i] = mask[i] && (SW'(i) > eff_pos);
    end
  end

  assign {nxt_found, nxt_pos} = lowest(rest);
  assign last = !nxt_found;

  always_comb begin
    sel_status = mtm_pkg::ST_DATA;
    case (eff_pos)
      4'd0:    sel_byte = {1'b1, cmd.delta[27:21]};
      4'd1:    sel_byte = {1'b1, cmd.delta[20:14]};
      4'd2:    sel_byte = {1'b1, cmd.delta[13:7]};
      4'd3:    sel_byte = {1'b0, cmd.delta[6:0]};
      4'd4:    sel_byte = cmd.b0;
      4'd5:    sel_byte = cmd.b1;
      4'd6:    sel_byte = cmd.b2;
      4'd7:    sel_byte = 8'h00;
      4'd8:    sel_byte = 8'hFF;
      4'd9:    sel_byte = 8'h2F;
      4'd10:   sel_byte = 8'h00;
      4'd11: begin
        sel_byte   = 8'h00;
        sel_status = cmd.fail ? mtm_pkg::ST_ERROR : mtm_pkg::ST_END;
      end
      default: sel_byte = 8'h00;
    endcase
  end

  assign advance = cmd_valid && (!out_valid_r || pop);
  assign cmd_pop = advance && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        started_r   <= !last;
        pos_r       <= nxt_pos;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r   <= sel_byte;
      out_last_r   <= last;
      out_status_r <= sel_status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule
